// File: rtl/core/ble_pkg.sv
`timescale 1ns / 1ps

package ble_pkg;

  localparam int VAL_W = 32;
  localparam int POS_W = 8;
  localparam int LEN_W = 9;

  localparam logic [3:0] FN_INSERT   = 4'd0;
  localparam logic [3:0] FN_DEL_HEAD = 4'd1;
  localparam logic [3:0] FN_DEL_POS  = 4'd2;
  localparam logic [3:0] FN_DEL_VAL  = 4'd3;
  localparam logic [3:0] FN_SORT     = 4'd4;
  localparam logic [3:0] FN_ABS_SORT = 4'd5;
  localparam logic [3:0] FN_READ     = 4'd6;
  localparam logic [3:0] FN_LENGTH   = 4'd7;
  localparam logic [3:0] FN_CLEAR    = 4'd8;

  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic [3:0]              func;
    logic signed [VAL_W-1:0] item_value;
    logic [POS_W-1:0]        position;
  } ble_in_t;

  typedef struct packed {
    logic [1:0]              status;
    logic signed [VAL_W-1:0] read_value;
    logic [LEN_W-1:0]        list_length;
  } ble_out_t;

  // Per-cell controls, decoded by the top level for each cell position.
  typedef struct packed {
    logic load_left;
    logic load_right;
    logic do_abs;
    logic sort_lo;
    logic sort_hi;
    logic is_sel;
    logic live;
    logic chain_clr;
  } ble_cell_ctl_t;

endpackage

// File: rtl/core/ble_cell.sv
`timescale 1ns / 1ps

module ble_cell (
  input  logic                              clk,
  input  ble_pkg::ble_cell_ctl_t            ctl,
  input  logic signed [ble_pkg::VAL_W-1:0]  key,
  input  logic signed [ble_pkg::VAL_W-1:0]  left_value,
  input  logic signed [ble_pkg::VAL_W-1:0]  right_value,
  input  logic                              hit_in,
  input  logic signed [ble_pkg::VAL_W-1:0]  rd_in,
  output logic signed [ble_pkg::VAL_W-1:0]  value,
  output logic                              hit,
  output logic signed [ble_pkg::VAL_W-1:0]  rd
);

  localparam logic signed [ble_pkg::VAL_W-1:0] VMIN = {1'b1, {(ble_pkg::VAL_W-1){1'b0}}};
  localparam logic signed [ble_pkg::VAL_W-1:0] VMAX = {1'b0, {(ble_pkg::VAL_W-1){1'b1}}};

  logic eq;

  assign eq = ctl.live && (value == key);

  always_ff @(posedge clk) begin
    priority if (ctl.load_left) begin
      value <= left_value;
    end else if (ctl.load_right) begin
      value <= right_value;
    end else if (ctl.do_abs) begin
      if (value == VMIN) begin
        value <= VMAX;
      end else if (value < 0) begin
        value <= -value;
      end
    end else if (ctl.sort_lo && (value > right_value)) begin
      value <= right_value;
    end else if (ctl.sort_hi && (left_value > value)) begin
      value <= left_value;
    end else begin
      value <= value;
    end
  end

  // The hit flag ripples toward the tail: once settled it tells whether any
  // live entry at or before this cell matches the key.
  always_ff @(posedge clk) begin
    if (ctl.chain_clr) begin
      hit <= 1'b0;
    end else begin
      hit <= eq || hit_in;
    end
  end

  // The read data ripples toward the head, picked up at the selected cell.
  always_ff @(posedge clk) begin
    rd <= ctl.is_sel ? value : rd_in;
  end

endmodule

// File: rtl/core/bounded_list_engine_with_sort.sv
`timescale 1ns / 1ps

// Ordered list engine holding up to LIST_DEPTH signed 32-bit entries in a
// row of cells. Commands arrive as items on the in channel (in_valid /
// in_ready / in_item) and each one yields exactly one result item on the out
// channel (out_valid / out_ready / out_item) with status, read value and the
// list length after the command.
// One command is worked on at a time. Insert, delete head, delete at
// position, length, clear and unknown codes go from acceptance straight
// to the final state. Sort, abs sort, read and delete by value first pass
// through a sweep state: sorting runs LIST_DEPTH rounds of odd-even exchange
// between neighboring cells, and the search and read chains ripple from one
// end of the row to the other.
// A finished result sits in the output register; the next command is
// accepted while it waits. If the receiver stalls, a second command completes
// its work and then holds before committing until the output register frees.
// Reset empties the list and drops any pending result; entry contents are
// not cleared.

module bounded_list_engine_with_sort #(
  parameter int LIST_DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  ble_pkg::ble_in_t  in_item,
  output logic              out_valid,
  input  logic              out_ready,
  output ble_pkg::ble_out_t out_item
);

  localparam int CNT_W  = $clog2(LIST_DEPTH + 1);
  localparam int STEP_W = $clog2(LIST_DEPTH);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_SWEEP = 3'b010,
    S_FINAL = 3'b100
  } state_t;

  state_t                 state;
  state_t                 state_next;
  logic [CNT_W-1:0]       count;
  logic [CNT_W-1:0]       count_next;
  logic [STEP_W-1:0]      step;
  ble_pkg::ble_in_t       cmd;

  logic                   accept;
  logic                   final_go;
  logic                   sorting;
  logic                   do_insert;
  logic                   do_del_head;
  logic                   do_del_pos;
  logic                   do_del_val;
  logic                   do_abs;
  logic                   is_full;
  logic                   pos_miss;
  logic [ble_pkg::LEN_W-1:0] pos_ext;
  logic [ble_pkg::LEN_W-1:0] cnt_ext;
  ble_pkg::ble_out_t      result;

  ble_pkg::ble_cell_ctl_t            ctl   [LIST_DEPTH];
  logic signed [ble_pkg::VAL_W-1:0]  value [LIST_DEPTH];
  logic signed [ble_pkg::VAL_W-1:0]  rd    [LIST_DEPTH];
  logic                              hit   [LIST_DEPTH];
  logic                              live  [LIST_DEPTH];

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign final_go = (state == S_FINAL) && (!out_valid || out_ready);

  assign pos_ext  = {1'b0, cmd.position};
  assign cnt_ext  = ble_pkg::LEN_W'(count);
  assign is_full  = (count == CNT_W'(LIST_DEPTH));
  assign pos_miss = (pos_ext >= cnt_ext);

  assign sorting     = (state == S_SWEEP) &&
                       ((cmd.func == ble_pkg::FN_SORT) || (cmd.func == ble_pkg::FN_ABS_SORT));
  assign do_abs      = accept && (in_item.func == ble_pkg::FN_ABS_SORT);
  assign do_insert   = final_go && (cmd.func == ble_pkg::FN_INSERT) && !is_full;
  assign do_del_head = final_go && (cmd.func == ble_pkg::FN_DEL_HEAD) && (count != '0);
  assign do_del_pos  = final_go && (cmd.func == ble_pkg::FN_DEL_POS) && !pos_miss;
  assign do_del_val  = final_go && (cmd.func == ble_pkg::FN_DEL_VAL) && hit[LIST_DEPTH-1];

  for (genvar g = 0; g < LIST_DEPTH; g++) begin : g_cell
    localparam logic PAR_LO = 1'(g % 2);
    localparam logic PAR_HI = 1'((g + 1) % 2);

    logic signed [ble_pkg::VAL_W-1:0] left_v;
    logic signed [ble_pkg::VAL_W-1:0] right_v;
    logic signed [ble_pkg::VAL_W-1:0] rd_in_v;
    logic                             hit_in_v;
    logic                             live_up;

    assign live[g] = (count > CNT_W'(g));

    if (g == 0) begin : g_head
      assign left_v   = cmd.item_value;
      assign hit_in_v = 1'b0;
    end else begin : g_mid
      assign left_v   = value[g-1];
      assign hit_in_v = hit[g-1];
    end

    if (g == LIST_DEPTH - 1) begin : g_tail
      assign right_v = '0;
      assign rd_in_v = '0;
      assign live_up = 1'b0;
    end else begin : g_body
      assign right_v = value[g+1];
      assign rd_in_v = rd[g+1];
      assign live_up = live[g+1];
    end

    always_comb begin
      ctl[g].load_left  = do_insert;
      ctl[g].load_right = do_del_head ||
                          (do_del_pos && (pos_ext <= ble_pkg::LEN_W'(g))) ||
                          (do_del_val && hit[g]);
      ctl[g].do_abs     = do_abs;
      ctl[g].sort_lo    = sorting && (step[0] == PAR_LO) && live_up;
      ctl[g].sort_hi    = sorting && (g > 0) && (step[0] == PAR_HI) && live[g];
      ctl[g].is_sel     = (cmd.position == ble_pkg::POS_W'(g));
      ctl[g].live       = live[g];
      ctl[g].chain_clr  = accept;
    end

    ble_cell u_cell (
      .clk         (clk),
      .ctl         (ctl[g]),
      .key         (cmd.item_value),
      .left_value  (left_v),
      .right_value (right_v),
      .hit_in      (hit_in_v),
      .rd_in       (rd_in_v),
      .value       (value[g]),
      .hit         (hit[g]),
      .rd          (rd[g])
    );
  end

  always_comb begin
    result.status      = ble_pkg::ST_DONE;
    result.read_value  = '0;
    count_next         = count;
    unique case (cmd.func)
      ble_pkg::FN_INSERT: begin
        if (is_full) begin
          result.status = ble_pkg::ST_FULL;
        end else begin
          count_next = count + 1'b1;
        end
      end
      ble_pkg::FN_DEL_HEAD: begin
        if (count == '0) begin
          result.status = ble_pkg::ST_MISS;
        end else begin
          count_next = count - 1'b1;
        end
      end
      ble_pkg::FN_DEL_POS: begin
        if (pos_miss) begin
          result.status = ble_pkg::ST_MISS;
        end else begin
          count_next = count - 1'b1;
        end
      end
      ble_pkg::FN_DEL_VAL: begin
        if (hit[LIST_DEPTH-1]) begin
          count_next = count - 1'b1;
        end else begin
          result.status = ble_pkg::ST_MISS;
        end
      end
      ble_pkg::FN_READ: begin
        if (pos_miss) begin
          result.status = ble_pkg::ST_MISS;
        end else begin
          result.read_value = rd[0];
        end
      end
      ble_pkg::FN_CLEAR: begin
        count_next = '0;
      end
      default: begin
      end
    endcase
    result.list_length = ble_pkg::LEN_W'(count_next);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if ((in_item.func == ble_pkg::FN_DEL_VAL) || (in_item.func == ble_pkg::FN_SORT) ||
              (in_item.func == ble_pkg::FN_ABS_SORT) || (in_item.func == ble_pkg::FN_READ)) begin
            state_next = S_SWEEP;
          end else begin
            state_next = S_FINAL;
          end
        end
      end
      S_SWEEP: begin
        if (step == STEP_W'(LIST_DEPTH - 1)) begin
          state_next = S_FINAL;
        end
      end
      S_FINAL: begin
        if (final_go) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        step <= '0;
      end else if (state == S_SWEEP) begin
        step <= step + 1'b1;
      end
      if (final_go) begin
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd <= in_item;
    end
    if (final_go) begin
      out_item <= result;
    end
  end

endmodule

// File: rtl/core/ble_checker.sv
`timescale 1ns / 1ps

module ble_checker #(
  parameter int LIST_DEPTH = 16
) (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input ble_pkg::ble_in_t  in_item,
  input logic              out_valid,
  input logic              out_ready,
  input ble_pkg::ble_out_t out_item
);

  // A result held back by the receiver stays put.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_item)))
    else $error("stalled result item changed or dropped");

  // Only one command is worked on at a time.
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second item accepted while a command is in progress");

  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_item.list_length <= ble_pkg::LEN_W'(LIST_DEPTH)))
    else $error("reported length exceeds list depth");

  assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_item.status != ble_pkg::ST_DONE)) |->
      ((out_item.read_value == '0) &&
       ((out_item.status == ble_pkg::ST_MISS) || (out_item.status == ble_pkg::ST_FULL))))
    else $error("failed command carries read data or an undefined status");

endmodule

bind bounded_list_engine_with_sort ble_checker #(.LIST_DEPTH(LIST_DEPTH)) u_ble_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);

// File: test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int LIST_DEPTH   = 16;
  localparam int RANDOM_ITEMS = 1430;
  localparam int STUCK_LIMIT  = 4000;
  localparam int HOLD_AFTER   = 300;
  localparam int HOLD_CYCLES  = 400;

  localparam logic signed [ble_pkg::VAL_W-1:0] VAL_MIN =
    {1'b1, {(ble_pkg::VAL_W-1){1'b0}}};
  localparam logic signed [ble_pkg::VAL_W-1:0] VAL_MAX =
    {1'b0, {(ble_pkg::VAL_W-1){1'b1}}};

  // Mirrors the list contents and queues the result each command should give.
  class list_scoreboard #(int DEPTH = 16);
    logic signed [ble_pkg::VAL_W-1:0] entries [DEPTH];
    int unsigned count;
    ble_pkg::ble_out_t result_q[$];
    int errors;

    function new();
      count = 0;
      errors = 0;
    endfunction

    function int pending();
      return result_q.size();
    endfunction

    function void remove_at(int idx);
      for (int i = idx; i + 1 < count; i++) entries[i] = entries[i + 1];
      count--;
    endfunction

    function void sort_entries();
      logic signed [ble_pkg::VAL_W-1:0] v;
      int p;
      for (int i = 1; i < count; i++) begin
        v = entries[i];
        p = i;
        while (p > 0 && entries[p - 1] > v) begin
          entries[p] = entries[p - 1];
          p--;
        end
        entries[p] = v;
      end
    endfunction

    function void note_command(ble_pkg::ble_in_t c);
      ble_pkg::ble_out_t r;
      int idx;
      r.status = ble_pkg::ST_DONE;
      r.read_value = '0;
      case (c.func)
        ble_pkg::FN_INSERT: begin
          if (count >= DEPTH) begin
            r.status = ble_pkg::ST_FULL;
          end else begin
            for (int i = count; i > 0; i--) entries[i] = entries[i - 1];
            entries[0] = c.item_value;
            count++;
          end
        end
        ble_pkg::FN_DEL_HEAD: begin
          if (count == 0) r.status = ble_pkg::ST_MISS;
          else remove_at(0);
        end
        ble_pkg::FN_DEL_POS: begin
          if (c.position >= count) r.status = ble_pkg::ST_MISS;
          else remove_at(c.position);
        end
        ble_pkg::FN_DEL_VAL: begin
          idx = -1;
          for (int i = 0; i < count; i++) begin
            if (idx < 0 && entries[i] == c.item_value) idx = i;
          end
          if (idx < 0) r.status = ble_pkg::ST_MISS;
          else remove_at(idx);
        end
        ble_pkg::FN_SORT: sort_entries();
        ble_pkg::FN_ABS_SORT: begin
          // The most negative value has no positive twin, so it saturates.
          for (int i = 0; i < count; i++) begin
            if (entries[i] == VAL_MIN) entries[i] = VAL_MAX;
            else if (entries[i] < 0) entries[i] = -entries[i];
          end
          sort_entries();
        end
        ble_pkg::FN_READ: begin
          if (c.position >= count) r.status = ble_pkg::ST_MISS;
          else r.read_value = entries[c.position];
        end
        ble_pkg::FN_CLEAR: count = 0;
        default: ;
      endcase
      r.list_length = ble_pkg::LEN_W'(count);
      result_q.push_back(r);
    endfunction

    function void check_result(ble_pkg::ble_out_t got);
      ble_pkg::ble_out_t want;
      if (result_q.size() == 0) begin
        $display("%0t: result with no command pending: status %0d value %0d length %0d",
                 $time, got.status, got.read_value, got.list_length);
        errors++;
        return;
      end
      want = result_q.pop_front();
      if (got.status !== want.status) begin
        $display("%0t: status mismatch: expected %0d, actual %0d",
                 $time, want.status, got.status);
        errors++;
      end
      if (got.read_value !== want.read_value) begin
        $display("%0t: read_value mismatch: expected %0d, actual %0d",
                 $time, want.read_value, got.read_value);
        errors++;
      end
      if (got.list_length !== want.list_length) begin
        $display("%0t: list_length mismatch: expected %0d, actual %0d",
                 $time, want.list_length, got.list_length);
        errors++;
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  ble_pkg::ble_in_t  in_item = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  ble_pkg::ble_out_t out_item;

  list_scoreboard #(LIST_DEPTH) sb;
  bit no_idle = 1'b0;
  int results_seen = 0;
  int stuck_cycles = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  int ready_gap = 0;

  bounded_list_engine_with_sort #(
    .LIST_DEPTH(LIST_DEPTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item(out_item)
  );

  always #5 clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    if (r < 99) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [ble_pkg::VAL_W-1:0] pick_value();
    int r;
    int s;
    r = $urandom_range(0, 99);
    s = int'($urandom_range(0, 16)) - 8;
    if (r < 8) return VAL_MIN;
    if (r < 14) return VAL_MAX;
    if (r < 40) return s;
    return $urandom;
  endfunction

  // Called at a falling edge; returns at a falling edge.
  task automatic send_cmd(logic [3:0] f, logic signed [ble_pkg::VAL_W-1:0] v,
                          logic [ble_pkg::POS_W-1:0] p);
    ble_pkg::ble_in_t c;
    int gap;
    c.func = f;
    c.item_value = v;
    c.position = p;
    in_item <= c;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    sb.note_command(c);
    @(negedge clk);
    gap = no_idle ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      sb.check_result(out_item);
      results_seen++;
    end
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) stuck_cycles = 0;
    else stuck_cycles++;
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Receiver: random stalls, plus one long hold-off so the block backs up.
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else if (!hold_done && results_seen >= HOLD_AFTER) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      out_ready <= 1'b0;
    end else if (no_idle) begin
      out_ready <= 1'b1;
    end else if (ready_gap > 0) begin
      out_ready <= 1'b0;
      ready_gap--;
    end else begin
      out_ready <= 1'b1;
      if ($urandom_range(0, 2) == 0) ready_gap = pick_gap();
    end
  end

  initial begin
    int cnt;
    int r;
    int ins_w;
    int fill_bias;
    logic [3:0] f;
    logic signed [ble_pkg::VAL_W-1:0] v;
    logic [ble_pkg::POS_W-1:0] p;

    sb = new();
    fill_bias = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Empty list cases.
    send_cmd(ble_pkg::FN_LENGTH, 0, 0);
    send_cmd(ble_pkg::FN_DEL_HEAD, 0, 0);
    send_cmd(ble_pkg::FN_READ, 0, 0);
    send_cmd(ble_pkg::FN_DEL_POS, 0, 0);
    send_cmd(ble_pkg::FN_DEL_VAL, VAL_MIN, 8'hff);
    // Field extremes, then reads at, past and far past the tail.
    send_cmd(ble_pkg::FN_INSERT, VAL_MIN, 0);
    send_cmd(ble_pkg::FN_INSERT, VAL_MAX, 8'hff);
    send_cmd(ble_pkg::FN_INSERT, -1, 0);
    send_cmd(ble_pkg::FN_INSERT, 0, 0);
    send_cmd(ble_pkg::FN_INSERT, 5, 0);
    send_cmd(ble_pkg::FN_READ, 0, 0);
    send_cmd(ble_pkg::FN_READ, 0, 4);
    send_cmd(ble_pkg::FN_READ, 0, 5);
    send_cmd(ble_pkg::FN_READ, 0, 8'hff);
    send_cmd(ble_pkg::FN_DEL_POS, 0, 5);
    send_cmd(ble_pkg::FN_SORT, 0, 0);
    send_cmd(ble_pkg::FN_READ, 0, 0);
    send_cmd(ble_pkg::FN_ABS_SORT, 0, 0);
    send_cmd(ble_pkg::FN_READ, 0, 4);
    send_cmd(ble_pkg::FN_DEL_VAL, 12345, 0);
    send_cmd(ble_pkg::FN_DEL_VAL, VAL_MAX, 0);
    send_cmd(ble_pkg::FN_DEL_POS, 0, 1);
    send_cmd(ble_pkg::FN_DEL_HEAD, 0, 0);
    send_cmd(4'hf, -1, 8'hff);
    send_cmd(ble_pkg::FN_CLEAR, 0, 0);
    drain_results();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 50 == 0) begin
        fill_bias = $urandom_range(0, 2);
        no_idle = ($urandom_range(0, 4) == 0);
      end
      if (n == RANDOM_ITEMS / 2) drain_results();

      cnt = sb.count;
      v = pick_value();
      p = ble_pkg::POS_W'($urandom_range(0, 255));
      ins_w = (fill_bias == 0) ? 55 : (fill_bias == 1) ? 35 : 15;
      r = $urandom_range(0, 99);
      if (r < ins_w) begin
        f = ble_pkg::FN_INSERT;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 12) f = ble_pkg::FN_DEL_HEAD;
        else if (r < 26) f = ble_pkg::FN_DEL_POS;
        else if (r < 40) f = ble_pkg::FN_DEL_VAL;
        else if (r < 50) f = ble_pkg::FN_SORT;
        else if (r < 60) f = ble_pkg::FN_ABS_SORT;
        else if (r < 80) f = ble_pkg::FN_READ;
        else if (r < 86) f = ble_pkg::FN_LENGTH;
        else if (r < 90) f = ble_pkg::FN_CLEAR;
        else f = 4'($urandom_range(int'(ble_pkg::FN_CLEAR) + 1, 15));
      end
      // Mostly aim at live entries so deletes and reads do real work.
      if (cnt > 0 && (f == ble_pkg::FN_DEL_POS || f == ble_pkg::FN_READ) &&
          $urandom_range(0, 99) < 85)
        p = ble_pkg::POS_W'($urandom_range(0, cnt - 1));
      if (cnt > 0 && f == ble_pkg::FN_DEL_VAL && $urandom_range(0, 99) < 80)
        v = sb.entries[$urandom_range(0, cnt - 1)];
      send_cmd(f, v, p);
    end

    no_idle = 1'b0;
    drain_results();
    repeat (LIST_DEPTH * 4) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: bounded_list_engine_with_sort.f
rtl/core/ble_pkg.sv
rtl/core/ble_cell.sv
rtl/core/bounded_list_engine_with_sort.sv
rtl/core/ble_checker.sv
test/tb_top.sv
